// ===== hdl/s5scan_pkg.sv =====
// Shared types and constants for the AML _S5_ sleep-type scanner.
// No dependencies; the core, the top level and the testbench import this package.

package s5scan_pkg;

	// Byte codes seen in the definition block body, the sleep-type shift and the name window size.
	localparam logic [31:0] NAME_S5     = 32'h5F53_355F;
	localparam logic [7:0]  OP_PACKAGE  = 8'h12;
	localparam logic [7:0]  OP_ONE      = 8'h01;
	localparam logic [7:0]  OP_BYTE     = 8'h0A;
	localparam logic [7:0]  OP_WORD     = 8'h0B;
	localparam logic [7:0]  OP_DWORD    = 8'h0C;
	localparam int          SLP_SHIFT   = 10;
	localparam int          SLP_KEEP    = 16 - SLP_SHIFT;
	localparam logic [2:0]  WINDOW_FULL = 3'd4;

	// Parser phase.
	typedef enum logic [3:0] {
		PH_SCAN    = 4'd0,
		PH_PKGLEN  = 4'd1,
		PH_PKGSKIP = 4'd2,
		PH_NUMEL   = 4'd3,
		PH_OP_A    = 4'd4,
		PH_BYTES_A = 4'd5,
		PH_OP_B    = 4'd6,
		PH_BYTES_B = 4'd7,
		PH_DONE    = 4'd8
	} phase_t;

	// One result item.
	typedef struct packed {
		logic        found;
		logic [15:0] sleep_type_a;
		logic [15:0] sleep_type_b;
	} result_t;

	// Place the low bits of an integer into a sleep-type field.
	function automatic logic [15:0] slp_field(input logic [SLP_KEEP-1:0] v);
		slp_field = {v, {SLP_SHIFT{1'b0}}};
	endfunction

endpackage

// ===== hdl/s5scan_in_if.sv =====
// Input channel of the scanner: one body byte per item with an end marker.
// No dependencies.

interface s5scan_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/s5scan_out_if.sv =====
// Output channel of the scanner: one sleep-type result per item.
// No dependencies.

interface s5scan_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] sleep_type_a;
	logic [15:0] sleep_type_b;

	modport source (output valid, output found, output sleep_type_a, output sleep_type_b,
		input ready);
	modport sink (input valid, input found, input sleep_type_a, input sleep_type_b,
		output ready);
endinterface

// ===== hdl/aml_s5_sleep_type_scanner.sv =====
// Top level of the AML _S5_ sleep-type scanner: input register, parser, result register.
// Depends on s5scan_pkg, s5scan_in_if, s5scan_out_if and s5scan_core.
//
//   channel   direction   carries
//   in_ch     sink        data_byte, last_byte
//   out_ch    source      found, sleep_type_a, sleep_type_b
//
// One byte is accepted per cycle unless stalled; any result goes on to the result register.
// The rate is set by the phase update loop in s5scan_core, one byte per cycle when not stalled.
// A stalled result holds both registers; the input register still takes a byte when empty.
// Reset clears the parser to the name scan and empties both registers.

module aml_s5_sleep_type_scanner
	import s5scan_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	s5scan_in_if.sink    in_ch,
	s5scan_out_if.source out_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       step;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	assign advance     = !out_valid_q || out_ch.ready;
	assign step        = valid_s1 && advance;
	assign in_ch.ready = advance || !valid_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	s5scan_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found        = out_q.found;
	assign out_ch.sleep_type_a = out_q.sleep_type_a;
	assign out_ch.sleep_type_b = out_q.sleep_type_b;

`ifndef SYNTHESIS
	// The sleep-type fields always carry zeros below the shift.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.sleep_type_a[SLP_SHIFT-1:0] == '0 &&
			out_q.sleep_type_b[SLP_SHIFT-1:0] == '0))
		else $error("sleep-type field has low bits set");

	// A miss report carries zero values.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.found) |-> (out_q.sleep_type_a == '0 && out_q.sleep_type_b == '0))
		else $error("miss report with nonzero values");

	// A byte held by an output stall stays in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("input register changed during a stall");
`endif

endmodule

// ===== hdl/s5scan_core.sv =====
// Parser state and next-state logic of the _S5_ scanner.
// Depends on s5scan_pkg.

module s5scan_core
	import s5scan_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       res_valid,
	output result_t    res
);

	logic [31:0]         window_q, window_d;
	logic [2:0]          fill_q, fill_d;
	phase_t              phase_q, phase_d;
	logic [1:0]          skip_q, skip_d;
	logic [2:0]          left_q, left_d;
	logic                first_byte_q, first_byte_d;
	logic [SLP_KEEP-1:0] acc_q, acc_d;
	logic [SLP_KEEP-1:0] first_q, first_d;

	logic                fin;
	logic [SLP_KEEP-1:0] fin_val;
	logic [1:0]          skip_dec;
	logic [2:0]          left_dec;

	// Next state for one byte.
	always_comb begin
		window_d     = window_q;
		fill_d       = fill_q;
		phase_d      = phase_q;
		skip_d       = skip_q;
		left_d       = left_q;
		first_byte_d = first_byte_q;
		acc_d        = acc_q;
		first_d      = first_q;
		fin          = 1'b0;
		fin_val      = '0;
		res_valid    = 1'b0;
		res          = '0;
		skip_dec     = skip_q - 2'd1;
		left_dec     = left_q - 3'd1;

		case (phase_q)
			PH_SCAN: begin
				if (fill_q == WINDOW_FULL && window_q == NAME_S5 && data_byte == OP_PACKAGE) begin
					phase_d = PH_PKGLEN;
				end else begin
					window_d = {window_q[23:0], data_byte};
					if (fill_q < WINDOW_FULL) begin
						fill_d = fill_q + 3'd1;
					end
				end
			end
			PH_PKGLEN: begin
				if (data_byte[7:6] == 2'd0) begin
					phase_d = PH_NUMEL;
				end else begin
					skip_d  = data_byte[7:6];
					phase_d = PH_PKGSKIP;
				end
			end
			PH_PKGSKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 2'd0) begin
					phase_d = PH_NUMEL;
				end
			end
			PH_NUMEL: begin
				phase_d = PH_OP_A;
			end
			PH_OP_A, PH_OP_B: begin
				acc_d        = '0;
				first_byte_d = 1'b1;
				if (data_byte inside {OP_BYTE, OP_WORD, OP_DWORD}) begin
					left_d  = (data_byte == OP_BYTE) ? 3'd1 : (data_byte == OP_WORD) ? 3'd2 : 3'd4;
					phase_d = (phase_q == PH_OP_A) ? PH_BYTES_A : PH_BYTES_B;
				end else begin
					fin     = 1'b1;
					fin_val = (data_byte == OP_ONE) ? SLP_KEEP'(1) : '0;
				end
			end
			PH_BYTES_A, PH_BYTES_B: begin
				// Only the lowest byte reaches the kept bits of the result.
				if (first_byte_q) begin
					acc_d = data_byte[SLP_KEEP-1:0];
				end
				first_byte_d = 1'b0;
				left_d       = left_dec;
				if (left_dec == 3'd0) begin
					fin     = 1'b1;
					fin_val = acc_d;
				end
			end
			default: begin
			end
		endcase

		// A finished integer is either stored or completes the pair.
		if (fin) begin
			if (phase_q == PH_OP_A || phase_q == PH_BYTES_A) begin
				first_d = fin_val;
				phase_d = PH_OP_B;
			end else begin
				res_valid        = 1'b1;
				res.found        = 1'b1;
				res.sleep_type_a = slp_field(first_q);
				res.sleep_type_b = slp_field(fin_val);
				phase_d          = PH_DONE;
			end
		end

		// End of block: report a miss if nothing was reported, then restart.
		if (last_byte) begin
			if (!res_valid && phase_d != PH_DONE) begin
				res_valid = 1'b1;
				res       = '0;
			end
			window_d     = '0;
			fill_d       = '0;
			phase_d      = PH_SCAN;
			skip_d       = '0;
			left_d       = '0;
			first_byte_d = 1'b0;
			acc_d        = '0;
			first_d      = '0;
		end
	end

	// State registers, updated once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			fill_q       <= '0;
			phase_q      <= PH_SCAN;
			skip_q       <= '0;
			left_q       <= '0;
			first_byte_q <= 1'b0;
			acc_q        <= '0;
			first_q      <= '0;
		end else if (step) begin
			window_q     <= window_d;
			fill_q       <= fill_d;
			phase_q      <= phase_d;
			skip_q       <= skip_d;
			left_q       <= left_d;
			first_byte_q <= first_byte_d;
			acc_q        <= acc_d;
			first_q      <= first_d;
		end
	end

endmodule

// ===== bench/tb_aml_s5_sleep_type_scanner.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for aml_s5_sleep_type_scanner: feeds AML body bytes and checks
// every sleep-type result against a built-in scanner model.
// Depends on s5scan_pkg, s5scan_in_if, s5scan_out_if and the scanner RTL.

module tb_aml_s5_sleep_type_scanner;
	import s5scan_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int FLUSH_CYCLES = 8;
	localparam int RANDOM_BYTES = 1000;
	localparam int TX_IDLE_FIRST = 38;
	localparam int RX_IDLE_FIRST = 51;
	localparam logic [7:0] OP_ZERO = 8'h00;
	localparam logic [7:0] CH_UNDER = NAME_S5[31:24];
	localparam logic [7:0] CH_S = NAME_S5[23:16];
	localparam logic [7:0] CH_FIVE = NAME_S5[15:8];

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} body_byte_t;

	logic clk;
	logic arst_n;

	s5scan_in_if in_ch();
	s5scan_out_if out_ch();

	aml_s5_sleep_type_scanner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	body_byte_t body_bytes[$];
	logic [7:0] block_buf[$];
	result_t expected_results[$];

	int stim_total;
	int accepted_count;
	int drain_point_a;
	int drain_point_b;
	int drain_seen;
	int idle_stage;
	int error_count;
	int cycle_count;
	bit drain_wait;
	bit drain_checked;

	// Scanner model state.
	logic [31:0] name_window;
	logic [2:0]  window_fill;
	phase_t      scan_phase;
	logic [1:0]  skip_left;
	logic [2:0]  int_left;
	logic [4:0]  int_shift;
	logic [31:0] int_acc;
	logic [15:0] first_val;

	// Sleep-type fields keep the low bits of the integer above the shift.
	function automatic logic [15:0] to_sleep_type(logic [15:0] v);
		return v << SLP_SHIFT;
	endfunction

	function automatic void clear_tracker();
		name_window = '0;
		window_fill = '0;
		scan_phase = PH_SCAN;
		skip_left = '0;
		int_left = '0;
		int_shift = '0;
		int_acc = '0;
		first_val = '0;
	endfunction

	// Advance the model by one body byte and queue the result it causes, if any.
	function automatic void track_byte(logic [7:0] b, logic is_last);
		bit emitted;
		bit int_done;
		logic [31:0] val;
		result_t res;
		emitted = 1'b0;
		int_done = 1'b0;
		val = '0;
		case (scan_phase)
			PH_SCAN: begin
				if (window_fill >= WINDOW_FULL && name_window == NAME_S5 && b == OP_PACKAGE) begin
					scan_phase = PH_PKGLEN;
				end else begin
					name_window = {name_window[23:0], b};
					if (window_fill < WINDOW_FULL)
						window_fill = window_fill + 3'd1;
				end
			end
			PH_PKGLEN: begin
				if (b[7:6] == 2'b00) begin
					scan_phase = PH_NUMEL;
				end else begin
					skip_left = b[7:6];
					scan_phase = PH_PKGSKIP;
				end
			end
			PH_PKGSKIP: begin
				skip_left = skip_left - 2'd1;
				if (skip_left == 2'd0)
					scan_phase = PH_NUMEL;
			end
			PH_NUMEL: scan_phase = PH_OP_A;
			PH_OP_A, PH_OP_B: begin
				int_acc = '0;
				int_shift = '0;
				if (b == OP_BYTE || b == OP_WORD || b == OP_DWORD) begin
					if (b == OP_BYTE)
						int_left = 3'd1;
					else if (b == OP_WORD)
						int_left = 3'd2;
					else
						int_left = 3'd4;
					if (scan_phase == PH_OP_A)
						scan_phase = PH_BYTES_A;
					else
						scan_phase = PH_BYTES_B;
				end else begin
					// Zero, one, and any unknown opcode all finish the integer at once.
					val = (b == OP_ONE) ? 32'd1 : 32'd0;
					int_done = 1'b1;
				end
			end
			PH_BYTES_A, PH_BYTES_B: begin
				int_acc = int_acc | ({24'd0, b} << (int_shift & 5'd24));
				int_shift = int_shift + 5'd8;
				int_left = int_left - 3'd1;
				if (int_left == 3'd0) begin
					val = int_acc;
					int_done = 1'b1;
				end
			end
			default: ;
		endcase

		// The first integer is held; the second one completes the result.
		if (int_done) begin
			if (scan_phase == PH_OP_A || scan_phase == PH_BYTES_A) begin
				first_val = val[15:0];
				scan_phase = PH_OP_B;
			end else begin
				res.found = 1'b1;
				res.sleep_type_a = to_sleep_type(first_val);
				res.sleep_type_b = to_sleep_type(val[15:0]);
				expected_results.push_back(res);
				emitted = 1'b1;
				scan_phase = PH_DONE;
			end
		end

		// End of block: report a miss unless the package was parsed, then start over.
		if (is_last) begin
			if (!emitted && scan_phase != PH_DONE) begin
				res = '0;
				expected_results.push_back(res);
			end
			clear_tracker();
		end
	endfunction

	// Move the first len bytes of the block buffer to the stimulus, marking the final one.
	task automatic commit_block(int len);
		body_byte_t item;
		for (int i = 0; i < len; i++) begin
			item.data = block_buf[i];
			item.last = (i == len - 1);
			body_bytes.push_back(item);
		end
		block_buf.delete();
	endtask

	task automatic add_name();
		block_buf.push_back(CH_UNDER);
		block_buf.push_back(CH_S);
		block_buf.push_back(CH_FIVE);
		block_buf.push_back(CH_UNDER);
	endtask

	// Append one package integer of a random encoding.
	task automatic add_integer();
		logic [7:0] op;
		case ($urandom_range(0, 5))
			0: block_buf.push_back(OP_ZERO);
			1: block_buf.push_back(OP_ONE);
			2: begin
				block_buf.push_back(OP_BYTE);
				block_buf.push_back(8'($urandom));
			end
			3: begin
				block_buf.push_back(OP_WORD);
				repeat (2) block_buf.push_back(8'($urandom));
			end
			4: begin
				block_buf.push_back(OP_DWORD);
				repeat (4) block_buf.push_back(8'($urandom));
			end
			default: begin
				do
					op = 8'($urandom);
				while (op == OP_ZERO || op == OP_ONE || op == OP_BYTE || op == OP_WORD ||
					op == OP_DWORD);
				block_buf.push_back(op);
			end
		endcase
	endtask

	// One random block: mostly a well-formed _S5_ package, some truncated, some pure noise.
	task automatic add_random_block();
		int pick;
		int top;
		int cut;
		logic [7:0] other;
		block_buf.delete();
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			repeat ($urandom_range(1, 16)) block_buf.push_back(8'($urandom));
			commit_block(block_buf.size());
		end else begin
			repeat ($urandom_range(0, 5)) block_buf.push_back(8'($urandom));
			if ($urandom_range(0, 3) == 0) begin
				block_buf.push_back(CH_UNDER);
				block_buf.push_back(CH_S);
			end
			add_name();
			// A name not followed by the package opcode must not commit the parser.
			if ($urandom_range(0, 7) == 0) begin
				do
					other = 8'($urandom);
				while (other == OP_PACKAGE);
				block_buf.push_back(other);
				add_name();
			end
			block_buf.push_back(OP_PACKAGE);
			top = $urandom_range(0, 3);
			block_buf.push_back({2'(top), 6'($urandom)});
			repeat (top) block_buf.push_back(8'($urandom));
			block_buf.push_back(8'($urandom));
			add_integer();
			add_integer();
			repeat ($urandom_range(0, 3)) block_buf.push_back(8'($urandom));
			cut = block_buf.size();
			if (pick < 30)
				cut = $urandom_range(1, block_buf.size());
			commit_block(cut);
		end
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Byte driver: offers the next pending item, idles at random, and drains at phase changes.
	always @(posedge clk) begin : byte_driver
		int taken;
		int tx_pct;
		body_byte_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			taken = accepted_count + ((in_ch.valid && in_ch.ready) ? 1 : 0);
			if (!in_ch.valid || in_ch.ready) begin
				if (drain_wait) begin
					// The item taken on the entry edge is predicted only after this pass, so the check waits for the next pass.
					if (drain_checked && expected_results.size() == 0)
						drain_wait = 1'b0;
					drain_checked = 1'b1;
				end else if ((taken == drain_point_a || taken == drain_point_b) &&
					taken != drain_seen) begin
					drain_wait = 1'b1;
					drain_checked = 1'b0;
					drain_seen = taken;
				end
				if (taken < drain_point_a)
					tx_pct = TX_IDLE_FIRST;
				else if (taken < drain_point_b)
					tx_pct = RX_IDLE_FIRST;
				else
					tx_pct = 0;
				if (!drain_wait && body_bytes.size() != 0 && $urandom_range(0, 99) >= tx_pct) begin
					nxt = body_bytes.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.data_byte <= nxt.data;
					in_ch.last_byte <= nxt.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			accepted_count <= taken;
			idle_stage <= (taken < drain_point_a) ? 0 : (taken < drain_point_b) ? 1 : 2;
		end
	end

	// Monitor: predicts on each accepted byte, checks each accepted result, drives ready.
	always @(posedge clk) begin : result_monitor
		result_t want;
		int rx_pct;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				track_byte(in_ch.data_byte, in_ch.last_byte);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with none expected: found %0d a %h b %h",
						out_ch.found, out_ch.sleep_type_a, out_ch.sleep_type_b);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, out_ch.found);
						error_count++;
					end
					if (out_ch.sleep_type_a !== want.sleep_type_a) begin
						$error("sleep_type_a: expected %h, got %h", want.sleep_type_a,
							out_ch.sleep_type_a);
						error_count++;
					end
					if (out_ch.sleep_type_b !== want.sleep_type_b) begin
						$error("sleep_type_b: expected %h, got %h", want.sleep_type_b,
							out_ch.sleep_type_b);
						error_count++;
					end
				end
			end
			if (idle_stage == 0)
				rx_pct = RX_IDLE_FIRST;
			else if (idle_stage == 1)
				rx_pct = TX_IDLE_FIRST;
			else
				rx_pct = 0;
			out_ch.ready <= ($urandom_range(0, 99) >= rx_pct);
		end
	end

	// Run limit.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus build, reset, and end of run.
	initial begin : main_flow
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		accepted_count = 0;
		idle_stage = 0;
		error_count = 0;
		drain_wait = 1'b0;
		drain_checked = 1'b0;
		drain_seen = -1;
		clear_tracker();

		// Byte integer 0xFF and word integer 0xFF34; the result lands on the final byte.
		block_buf = '{CH_UNDER, CH_S, CH_FIVE, CH_UNDER, OP_PACKAGE, 8'h00, 8'h02,
			OP_BYTE, 8'hFF, OP_WORD, 8'h34, 8'hFF};
		commit_block(block_buf.size());
		// Name without the package opcode, and the block ends before any result.
		block_buf = '{CH_UNDER, CH_S, CH_FIVE, CH_UNDER, 8'h00};
		commit_block(block_buf.size());
		// Longest package length, one opcode, an unknown opcode, then an ignored trailing byte.
		block_buf = '{CH_UNDER, CH_S, CH_FIVE, CH_UNDER, OP_PACKAGE, 8'hFF, 8'h00, 8'h00,
			8'h00, 8'h02, OP_ONE, 8'h07, 8'hAA};
		commit_block(block_buf.size());

		while (body_bytes.size() < RANDOM_BYTES)
			add_random_block();

		stim_total = body_bytes.size();
		drain_point_a = stim_total / 3;
		drain_point_b = (2 * stim_total) / 3;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count != stim_total || expected_results.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/s5scan_pkg.sv
hdl/s5scan_in_if.sv
hdl/s5scan_out_if.sv
hdl/s5scan_core.sv
hdl/aml_s5_sleep_type_scanner.sv
bench/tb_aml_s5_sleep_type_scanner.sv
